FILE: rtl/core/imhq_pkg.sv
// Shared types and codes for the indexed max-heap queue.
package imhq_pkg;

    localparam int unsigned OP_BITS     = 2;
    localparam int unsigned ID_BITS     = 6;
    localparam int unsigned KEYF_BITS   = 32;
    localparam int unsigned STATUS_BITS = 3;
    localparam int unsigned COUNT_BITS  = 7;

    localparam logic [OP_BITS-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_EXTRACT = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CHANGE  = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_PRESENT = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT  = 3'd4;

    typedef struct packed {
        logic [OP_BITS-1:0]          operation;
        logic [ID_BITS-1:0]          entry_id;
        logic signed [KEYF_BITS-1:0] key_value;
    } request_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]      status;
        logic [ID_BITS-1:0]          out_id;
        logic signed [KEYF_BITS-1:0] out_key;
        logic [COUNT_BITS-1:0]       entry_count;
    } result_t;

endpackage

FILE: rtl/core/imhq_heap_mem.sv
// Heap store: one key/id entry per slot, one write and two registered reads.
module imhq_heap_mem #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned AW     = 6,
    parameter int unsigned KW     = 32,
    parameter int unsigned IW     = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [KW-1:0] wr_key,
    input  logic [IW-1:0] wr_id,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [KW-1:0] rd_key_a,
    output logic [IW-1:0] rd_id_a,
    output logic [KW-1:0] rd_key_b,
    output logic [IW-1:0] rd_id_b
);
    logic [KW+IW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_key, wr_id};
        end
        {rd_key_a, rd_id_a} <= mem[rd_addr_a];
        {rd_key_b, rd_id_b} <= mem[rd_addr_b];
    end
endmodule

FILE: rtl/core/imhq_slot_map.sv
// Position map from id to heap slot, with presence bits cleared at reset.
module imhq_slot_map #(
    parameter int unsigned IDS = 64,
    parameter int unsigned IW  = 6,
    parameter int unsigned AW  = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_id,
    input  logic [AW-1:0] wr_slot,
    input  logic [IW-1:0] rd_id,
    output logic [AW-1:0] rd_slot,
    input  logic          pres_set,
    input  logic          pres_clr,
    input  logic [IW-1:0] pres_id,
    input  logic [IW-1:0] test_id,
    output logic          test_present
);
    logic [AW-1:0] mem [IDS];
    logic [IDS-1:0] present_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_id] <= wr_slot;
        end
        rd_slot <= mem[rd_id];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
        end else if (pres_set) begin
            present_reg[pres_id] <= 1'b1;
        end else if (pres_clr) begin
            present_reg[pres_id] <= 1'b0;
        end
    end

    assign test_present = present_reg[test_id];
endmodule

FILE: rtl/core/indexed_max_heap_queue.sv
// Top level of the indexed max-heap priority queue: sequencer and handshakes.
//
//  channel | direction | struct    | handshake
//  s_      | in        | request_t | s_valid / s_ready
//  m_      | out       | result_t  | m_valid / m_ready
//
// One request at a time. Errors and unused codes raise m_valid the cycle after
// acceptance. Otherwise the entry is walked through the heap one level at a time,
// with a read, a compare and a swap write per level, until it lands: insert sifts
// up, extract moves the last entry to the root and sifts down, change rewrites the key
// and sifts either way. The single heap memory with one write port serializes these steps.
// Reset (aresetn, synchronous) empties the queue and clears presence bits.
// A new request is taken once the result register is free.
module indexed_max_heap_queue #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned ID_COUNT = 64,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  imhq_pkg::request_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output imhq_pkg::result_t  m_data
);
    import imhq_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = CW + 1;
    localparam logic signed [KEY_BITS-1:0] KMAX = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam logic signed [KEY_BITS-1:0] KMIN = {1'b1, {(KEY_BITS-1){1'b0}}};

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MAPRD  = 10'b0000000010,
        S_CHGRD  = 10'b0000000100,
        S_CHGWR  = 10'b0000001000,
        S_UPRD   = 10'b0000010000,
        S_UPCMP  = 10'b0000100000,
        S_DNRD   = 10'b0001000000,
        S_DNCMP  = 10'b0010000000,
        S_SWAP   = 10'b0100000000,
        S_EXTRD  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    request_t req_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] cur_reg, oth_reg;                  // current slot, swap partner
    logic signed [KEY_BITS-1:0] cur_key_reg, oth_key_reg;
    logic [IW-1:0] cur_id_reg, oth_id_reg;
    logic signed [KEY_BITS-1:0] new_key_reg;          // key reported in the result
    logic [IW-1:0] ext_id_reg;                        // id reported by an extract
    logic up_reg;                                     // sift direction after swap
    logic m_valid_reg;
    result_t res_reg;

    // memory ports
    logic          hw_en;
    logic [AW-1:0] hw_addr;
    logic [KEY_BITS-1:0] hw_key;
    logic [IW-1:0] hw_id;
    logic [AW-1:0] hr_a, hr_b;
    logic signed [KEY_BITS-1:0] hk_a, hk_b;
    logic [IW-1:0] hi_a, hi_b;
    logic          mw_en;
    logic [IW-1:0] mw_id;
    logic [AW-1:0] mw_slot;
    logic [IW-1:0] mr_id;
    logic [AW-1:0] mr_slot;
    logic          p_set, p_clr;
    logic [IW-1:0] p_id;
    logic          t_present;

    imhq_heap_mem #(.DEPTH(CAPACITY), .AW(AW), .KW(KEY_BITS), .IW(IW)) u_heap (
        .aclk(aclk), .wr_en(hw_en), .wr_addr(hw_addr), .wr_key(hw_key), .wr_id(hw_id),
        .rd_addr_a(hr_a), .rd_addr_b(hr_b), .rd_key_a(hk_a), .rd_id_a(hi_a),
        .rd_key_b(hk_b), .rd_id_b(hi_b)
    );

    imhq_slot_map #(.IDS(ID_COUNT), .IW(IW), .AW(AW)) u_map (
        .aclk(aclk), .aresetn(aresetn), .wr_en(mw_en), .wr_id(mw_id), .wr_slot(mw_slot),
        .rd_id(mr_id), .rd_slot(mr_slot), .pres_set(p_set), .pres_clr(p_clr),
        .pres_id(p_id), .test_id(s_data.entry_id[IW-1:0]), .test_present(t_present)
    );

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // input decode
    logic id_ok;
    logic [6:0] id_wide;
    assign id_wide = 7'(s_data.entry_id);
    assign id_ok = id_wide < 7'(ID_COUNT);

    logic signed [KEY_BITS-1:0] in_key;
    assign in_key = KEY_BITS'(s_data.key_value);

    // saturating add of the stored key and the delta
    logic signed [KEY_BITS:0] sum_w;
    logic signed [KEY_BITS-1:0] sat_key;
    assign sum_w = {hk_a[KEY_BITS-1], hk_a} +
                   {req_reg.key_value[KEY_BITS-1], KEY_BITS'(req_reg.key_value)};
    always_comb begin
        if (sum_w[KEY_BITS] != sum_w[KEY_BITS-1]) begin
            sat_key = sum_w[KEY_BITS] ? KMIN : KMAX;
        end else begin
            sat_key = sum_w[KEY_BITS-1:0];
        end
    end

    // tree addressing
    logic [PW-1:0] lc_w, rc_w;
    assign lc_w = PW'({cur_reg, 1'b1});
    assign rc_w = lc_w + PW'(1);
    logic [AW-1:0] par_w;
    assign par_w = AW'((cur_reg - AW'(1)) >> 1);

    logic signed [KEY_BITS-1:0] kl, kr;
    assign kl = hk_a;
    assign kr = hk_b;
    logic l_in, r_in, pick_r;
    assign l_in = lc_w < PW'(count_reg);
    assign r_in = rc_w < PW'(count_reg);
    assign pick_r = r_in && (kl < kr);

    logic                 res_load;
    result_t              res_next;
    logic [CW-1:0]        count_next;

    always_comb begin
        state_next = state_reg;
        hw_en = 1'b0; hw_addr = cur_reg; hw_key = cur_key_reg; hw_id = cur_id_reg;
        hr_a = cur_reg; hr_b = cur_reg;
        mw_en = 1'b0; mw_id = cur_id_reg; mw_slot = cur_reg;
        mr_id = s_data.entry_id[IW-1:0];
        p_set = 1'b0; p_clr = 1'b0; p_id = s_data.entry_id[IW-1:0];
        res_load = 1'b0;
        res_next = '0;
        res_next.status = ST_OK;
        res_next.entry_count = COUNT_BITS'(count_reg);
        count_next = count_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_load = 1'b1;
                    case (s_data.operation)
                        OP_INSERT: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                res_next.status = ST_FULL;
                            end else if (!id_ok) begin
                                res_next.status = ST_ABSENT;
                            end else if (t_present) begin
                                res_next.status = ST_PRESENT;
                            end else begin
                                // place last, then sift up
                                res_load = 1'b0;
                                hw_en = 1'b1; hw_addr = AW'(count_reg);
                                hw_key = in_key; hw_id = s_data.entry_id[IW-1:0];
                                mw_en = 1'b1; mw_id = s_data.entry_id[IW-1:0];
                                mw_slot = AW'(count_reg);
                                p_set = 1'b1;
                                count_next = count_reg + CW'(1);
                                state_next = S_UPRD;
                            end
                        end
                        OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                res_load = 1'b0;
                                hr_a = '0; hr_b = AW'(count_reg - CW'(1));
                                state_next = S_EXTRD;
                            end
                        end
                        OP_CHANGE: begin
                            if (!id_ok || !t_present) begin
                                res_next.status = ST_ABSENT;
                            end else begin
                                res_load = 1'b0;
                                state_next = S_MAPRD;
                            end
                        end
                        default: begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end
            S_MAPRD: begin
                hr_a = mr_slot;
                state_next = S_CHGRD;
            end
            S_CHGRD: begin
                state_next = S_CHGWR;
            end
            S_CHGWR: begin
                hw_en = 1'b1; hw_addr = cur_reg; hw_key = sat_key; hw_id = cur_id_reg;
                state_next = (hk_a < sat_key) ? S_UPRD : S_DNRD;
            end
            S_UPRD: begin
                if (cur_reg == '0) begin
                    // land: write the moving entry and its map slot here
                    hw_en = 1'b1; mw_en = 1'b1;
                    state_next = S_IDLE;
                    res_load = 1'b1;
                end else begin
                    hr_a = par_w;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (hk_a < cur_key_reg) begin
                    state_next = S_SWAP;
                end else begin
                    hw_en = 1'b1; mw_en = 1'b1;
                    state_next = S_IDLE;
                    res_load = 1'b1;
                end
            end
            S_DNRD: begin
                if (!l_in) begin
                    hw_en = 1'b1; mw_en = 1'b1;
                    state_next = S_IDLE;
                    res_load = 1'b1;
                end else begin
                    hr_a = AW'(lc_w); hr_b = AW'(rc_w);
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP: begin
                if (cur_key_reg < (pick_r ? kr : kl)) begin
                    state_next = S_SWAP;
                end else begin
                    hw_en = 1'b1; mw_en = 1'b1;
                    state_next = S_IDLE;
                    res_load = 1'b1;
                end
            end
            S_SWAP: begin
                // write partner into current slot; current entry moves to partner
                hw_en = 1'b1; hw_addr = cur_reg; hw_key = oth_key_reg; hw_id = oth_id_reg;
                mw_en = 1'b1; mw_id = oth_id_reg; mw_slot = cur_reg;
                state_next = up_reg ? S_UPRD : S_DNRD;
            end
            S_EXTRD: begin
                // root out, last entry to root
                hw_en = 1'b1; hw_addr = '0; hw_key = hk_b; hw_id = hi_b;
                mw_en = 1'b1; mw_id = hi_b; mw_slot = '0;
                p_clr = 1'b1; p_id = hi_a;
                count_next = count_reg - CW'(1);
                state_next = S_DNRD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // finished walk: report the extracted entry or the new key
        if (state_reg != S_IDLE) begin
            res_next.out_id  = (req_reg.operation == OP_EXTRACT) ? ID_BITS'(ext_id_reg) : '0;
            res_next.out_key = (req_reg.operation == OP_INSERT) ? '0
                                                                : KEYF_BITS'(new_key_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res_next;
        end
        if (s_fire) begin
            req_reg     <= s_data;
            cur_reg     <= AW'(count_reg);
            cur_key_reg <= in_key;
            cur_id_reg  <= s_data.entry_id[IW-1:0];
            up_reg      <= 1'b1;
        end
        case (state_reg)
            S_MAPRD: cur_reg <= mr_slot;
            S_CHGWR: begin
                cur_key_reg <= sat_key;
                new_key_reg <= sat_key;
                up_reg      <= hk_a < sat_key;
            end
            S_CHGRD: cur_id_reg <= hi_a;
            S_UPRD: oth_reg <= par_w;
            S_UPCMP: begin
                oth_key_reg <= hk_a;
                oth_id_reg  <= hi_a;
            end
            S_DNCMP: begin
                oth_reg     <= pick_r ? AW'(rc_w) : AW'(lc_w);
                oth_key_reg <= pick_r ? kr : kl;
                oth_id_reg  <= pick_r ? hi_b : hi_a;
            end
            S_SWAP: cur_reg <= oth_reg;
            S_EXTRD: begin
                cur_reg     <= '0;
                cur_key_reg <= hk_b;
                cur_id_reg  <= hi_b;
                new_key_reg <= hk_a;
                ext_id_reg  <= hi_a;
                up_reg      <= 1'b0;
            end
            default: begin
            end
        endcase
    end
endmodule
